[hdl/i2r_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the microcode table for the integer to Roman
// numeral encoder. No dependencies.
package i2r_pkg;

    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 8;
    localparam int PC_W     = 5;

    localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);

    localparam logic [SYMBOL_W-1:0] CH_NONE = 8'h00;
    localparam logic [SYMBOL_W-1:0] CH_I    = 8'h49;
    localparam logic [SYMBOL_W-1:0] CH_V    = 8'h56;
    localparam logic [SYMBOL_W-1:0] CH_X    = 8'h58;
    localparam logic [SYMBOL_W-1:0] CH_L    = 8'h4C;
    localparam logic [SYMBOL_W-1:0] CH_C    = 8'h43;
    localparam logic [SYMBOL_W-1:0] CH_D    = 8'h44;
    localparam logic [SYMBOL_W-1:0] CH_M    = 8'h4D;

    // Micro-operations
    typedef enum logic [2:0] {
        OP_CHECK,   // range check, emit error word if out of range
        OP_REPEAT,  // while rem >= thresh: emit, subtract, stay
        OP_HEAD,    // if rem >= thresh: emit first letter of a pair, else jump
        OP_TAIL,    // emit second letter of a pair, subtract
        OP_SINGLE   // if rem >= thresh: emit, subtract; advance either way
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [VALUE_W-1:0]  thresh;
        logic [SYMBOL_W-1:0] letter;
        logic [PC_W-1:0]     jump;
    } ctl_t;

    // Step counter values that are jump targets
    localparam logic [PC_W-1:0] PC_D    = PC_W'(4);
    localparam logic [PC_W-1:0] PC_C    = PC_W'(7);
    localparam logic [PC_W-1:0] PC_L    = PC_W'(10);
    localparam logic [PC_W-1:0] PC_X    = PC_W'(13);
    localparam logic [PC_W-1:0] PC_V    = PC_W'(16);
    localparam logic [PC_W-1:0] PC_I    = PC_W'(19);
    localparam logic [PC_W-1:0] PC_ZERO = PC_W'(0);

    localparam int UCODE_DEPTH = 20;

    function automatic ctl_t mk(op_t op, int thresh, logic [SYMBOL_W-1:0] letter,
                                logic [PC_W-1:0] jump);
        ctl_t c;
        c.op     = op;
        c.thresh = VALUE_W'(thresh);
        c.letter = letter;
        c.jump   = jump;
        return c;
    endfunction

    // Greedy Roman program: 1000 900 500 400 100 90 50 40 10 9 5 4 1
    function automatic ctl_t ucode(logic [PC_W-1:0] pc);
        ctl_t c;
        case (pc)
            5'd0:    c = mk(OP_CHECK,  0,    CH_NONE, PC_ZERO);
            5'd1:    c = mk(OP_REPEAT, 1000, CH_M,    PC_ZERO);
            5'd2:    c = mk(OP_HEAD,   900,  CH_C,    PC_D);
            5'd3:    c = mk(OP_TAIL,   900,  CH_M,    PC_ZERO);
            5'd4:    c = mk(OP_SINGLE, 500,  CH_D,    PC_ZERO);
            5'd5:    c = mk(OP_HEAD,   400,  CH_C,    PC_C);
            5'd6:    c = mk(OP_TAIL,   400,  CH_D,    PC_ZERO);
            5'd7:    c = mk(OP_REPEAT, 100,  CH_C,    PC_ZERO);
            5'd8:    c = mk(OP_HEAD,   90,   CH_X,    PC_L);
            5'd9:    c = mk(OP_TAIL,   90,   CH_C,    PC_ZERO);
            5'd10:   c = mk(OP_SINGLE, 50,   CH_L,    PC_ZERO);
            5'd11:   c = mk(OP_HEAD,   40,   CH_X,    PC_X);
            5'd12:   c = mk(OP_TAIL,   40,   CH_L,    PC_ZERO);
            5'd13:   c = mk(OP_REPEAT, 10,   CH_X,    PC_ZERO);
            5'd14:   c = mk(OP_HEAD,   9,    CH_I,    PC_V);
            5'd15:   c = mk(OP_TAIL,   9,    CH_X,    PC_ZERO);
            5'd16:   c = mk(OP_SINGLE, 5,    CH_V,    PC_ZERO);
            5'd17:   c = mk(OP_HEAD,   4,    CH_I,    PC_I);
            5'd18:   c = mk(OP_TAIL,   4,    CH_V,    PC_ZERO);
            5'd19:   c = mk(OP_REPEAT, 1,    CH_I,    PC_ZERO);
            default: c = mk(OP_CHECK,  0,    CH_NONE, PC_ZERO);
        endcase
        return c;
    endfunction

endpackage

[hdl/i2r_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the encoder: integer in, numeral out.
// Depends on i2r_pkg.
interface i2r_value_if import i2r_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2r_symbol_if import i2r_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                error;

    modport source (output valid, output symbol, output last, output error, input ready);
    modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

[hdl/integer_to_roman_encoder_core.sv]
`timescale 1ns / 1ps
// Integer to Roman numeral encoder, top level.
// Depends on i2r_pkg and the channel interfaces in i2r_if.sv.
//
// Takes one 12-bit integer word on `number` and sends its Roman numeral on
// `numeral`, one ASCII letter per word, with `last` on the final letter. A
// value of 0 or above 3999 gives a single word with error and last set and
// symbol 0. A microcode sequencer walks a 20-step program (range check, then
// the greedy values 1000, 900, 500 ... 4, 1) and handles one step or one
// emitted letter at a time; it holds while the output sink stalls. The
// output word sits in its own register, so the next value is taken as soon
// as the last letter has been loaded there, even while that letter still
// waits to be taken.
module integer_to_roman_encoder_core
    import i2r_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    i2r_value_if.sink           number,
    i2r_symbol_if.source        numeral
);

    // Sequencer state
    logic                busy_reg,  busy_next;
    logic [PC_W-1:0]     pc_reg,    pc_next;
    logic [VALUE_W-1:0]  rem_reg,   rem_next;

    // Output word register
    logic                valid_reg, valid_next;
    logic [SYMBOL_W-1:0] sym_reg,   sym_next;
    logic                last_reg,  last_next;
    logic                err_reg,   err_next;

    ctl_t                ctl;
    logic                slot_free;
    logic                ge;
    logic [VALUE_W-1:0]  diff;
    logic                zero_after;

    assign ctl        = ucode(pc_reg);
    assign slot_free  = !valid_reg || numeral.ready;
    assign ge         = rem_reg >= ctl.thresh;
    assign diff       = rem_reg - ctl.thresh;
    assign zero_after = diff == '0;

    assign number.ready   = !busy_reg;
    assign numeral.valid  = valid_reg;
    assign numeral.symbol = sym_reg;
    assign numeral.last   = last_reg;
    assign numeral.error  = err_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        err_next   = err_reg;

        // Drop the word once the sink takes it
        if (valid_reg && numeral.ready)
        begin
            valid_next = 1'b0;
        end

        if (!busy_reg)
        begin
            // Load a new value and start the program
            if (number.valid)
            begin
                busy_next = 1'b1;
                pc_next   = PC_ZERO;
                rem_next  = number.value;
            end
        end
        else if (slot_free)
        begin
            unique case (ctl.op)
                OP_CHECK:
                begin
                    if (rem_reg == '0 || rem_reg > MAX_VALUE)
                    begin
                        valid_next = 1'b1;
                        sym_next   = CH_NONE;
                        last_next  = 1'b1;
                        err_next   = 1'b1;
                        busy_next  = 1'b0;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
                OP_REPEAT:
                begin
                    if (ge)
                    begin
                        valid_next = 1'b1;
                        sym_next   = ctl.letter;
                        last_next  = zero_after;
                        err_next   = 1'b0;
                        rem_next   = diff;
                        busy_next  = !zero_after;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
                OP_HEAD:
                begin
                    // First letter of a subtractive pair; never the last
                    if (ge)
                    begin
                        valid_next = 1'b1;
                        sym_next   = ctl.letter;
                        last_next  = 1'b0;
                        err_next   = 1'b0;
                        pc_next    = pc_reg + 1'b1;
                    end
                    else
                    begin
                        pc_next = ctl.jump;
                    end
                end
                OP_TAIL:
                begin
                    valid_next = 1'b1;
                    sym_next   = ctl.letter;
                    last_next  = zero_after;
                    err_next   = 1'b0;
                    rem_next   = diff;
                    busy_next  = !zero_after;
                    pc_next    = pc_reg + 1'b1;
                end
                OP_SINGLE:
                begin
                    if (ge)
                    begin
                        valid_next = 1'b1;
                        sym_next   = ctl.letter;
                        last_next  = zero_after;
                        err_next   = 1'b0;
                        rem_next   = diff;
                        busy_next  = !zero_after;
                    end
                    pc_next = pc_reg + 1'b1;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pc_reg    <= PC_ZERO;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pc_reg    <= pc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

`ifndef SYNTHESIS
    // The program counter never runs past the final step while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg < PC_W'(UCODE_DEPTH))
        else $error("step counter beyond microcode");

    // An error word carries no letter and closes the item
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> (last_reg && sym_reg == CH_NONE))
        else $error("malformed error word");

    // An accepted value starts the program at the range check
    assert property (@(posedge clk) disable iff (!rst_n)
        (number.valid && number.ready) |=> (busy_reg && pc_reg == PC_ZERO))
        else $error("accept did not start program");

    // A stalled output slot freezes the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && valid_reg && !numeral.ready) |=>
            ($stable(pc_reg) && $stable(rem_reg) && busy_reg))
        else $error("sequencer advanced while output stalled");
`endif

endmodule
